FILE: design/assert_macros.svh
// Assertion macros used by the binomial pricer sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
    else $error("assertion lbl failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
    else $error("assertion lbl failed");

`endif

FILE: design/btop_pkg.sv
// Types and constants of the binomial option pricer
package btop_pkg;

  localparam int unsigned DefMaxSteps = 256;

  localparam logic [63:0] HalfQ30 = 64'd1 << 29;
  localparam logic [30:0] OneQ30  = 31'd1 << 30;

  localparam logic [2:0] RegPut    = 3'd0;
  localparam logic [2:0] RegStrike = 3'd1;
  localparam logic [2:0] RegUp     = 3'd2;
  localparam logic [2:0] RegDown   = 3'd3;
  localparam logic [2:0] RegProb   = 3'd4;
  localparam logic [2:0] RegDisc   = 3'd5;
  localparam logic [2:0] RegSteps  = 3'd6;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_LEAF,
    OP_PAYOFF,
    OP_MIX0,
    OP_MIX1,
    OP_DISC
  } cell_op_e;

  typedef struct packed {
    logic        is_put;
    logic [31:0] strike;
    logic [31:0] up;
    logic [31:0] down;
    logic [30:0] prob;
    logic [30:0] prob_c;
    logic [30:0] disc;
  } cfg_t;

  typedef struct packed {
    cell_op_e    op;
    logic [31:0] coef;
    logic [31:0] coef_alt;
    logic [31:0] strike;
    logic        is_put;
    logic [31:0] spot;
  } cell_ctl_t;

endpackage

FILE: design/binomial_tree_option_price.sv
// One price at a time: busy stays high until the done beat, so no new start is taken before the price is through.
// Leaf pricing takes one multiply per cell per cycle; each level then runs the MIX0, MIX1 and DISC steps.
// The result beat shows for one cycle on done_o; the receiver cannot stall it.
// Reset clears the registers to their defaults and idles the sequencer; node values hold garbage.
module binomial_tree_option_price import btop_pkg::*; #(
  parameter int unsigned MaxSteps = DefMaxSteps,
  localparam int unsigned CntW    = $clog2(MaxSteps + 1),
  localparam int unsigned NW      = (CntW > 9) ? CntW : 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] spot_price_i,
  output logic        done_o,
  output logic [31:0] option_value_o,
  output logic        saturated_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        put_q;
  logic [31:0] strike_q, up_q, down_q;
  logic [30:0] prob_q, disc_q;
  logic [8:0]  steps_q;
  logic        wr_en;
  logic [2:0]  reg_idx;
  logic [30:0] prob_eff;
  logic [CntW-1:0] n_eff;
  cfg_t        cfg;
  cell_ctl_t   ctl;
  logic [CntW-1:0] step;

  logic [31:0] val [MaxSteps+2];
  logic        sat [MaxSteps+2];

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      put_q    <= 1'b0;
      strike_q <= '0;
      up_q     <= 32'h4000_0000;
      down_q   <= 32'h4000_0000;
      prob_q   <= 31'h2000_0000;
      disc_q   <= 31'h4000_0000;
      steps_q  <= 9'd1;
    end else if (wr_en) begin
      case (reg_idx)
        RegPut:    put_q    <= pwdata[0];
        RegStrike: strike_q <= pwdata;
        RegUp:     up_q     <= pwdata;
        RegDown:   down_q   <= pwdata;
        RegProb:   prob_q   <= pwdata[30:0];
        RegDisc:   disc_q   <= pwdata[30:0];
        RegSteps:  steps_q  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPut:    prdata = {31'd0, put_q};
      RegStrike: prdata = strike_q;
      RegUp:     prdata = up_q;
      RegDown:   prdata = down_q;
      RegProb:   prdata = {1'b0, prob_q};
      RegDisc:   prdata = {1'b0, disc_q};
      RegSteps:  prdata = {23'd0, steps_q};
      default:   prdata = '0;
    endcase
  end

  assign prob_eff = (prob_q > OneQ30) ? OneQ30 : prob_q;
  assign n_eff    = (NW'(steps_q) > NW'(MaxSteps)) ? CntW'(MaxSteps) : CntW'(steps_q);

  always_comb begin
    cfg.is_put = put_q;
    cfg.strike = strike_q;
    cfg.up     = up_q;
    cfg.down   = down_q;
    cfg.prob   = prob_eff;
    cfg.prob_c = OneQ30 - prob_eff;
    cfg.disc   = disc_q;
  end

  btop_ctrl #(.MaxSteps(MaxSteps)) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .spot_i  (spot_price_i),
    .cfg_i   (cfg),
    .steps_i (n_eff),
    .ctl_o   (ctl),
    .step_o  (step),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  assign val[MaxSteps+1] = '0;
  assign sat[MaxSteps+1] = 1'b0;

  for (genvar g = 0; g <= MaxSteps; g++) begin : g_cell
    btop_cell #(.MaxSteps(MaxSteps), .Index(g)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .step_i     (step),
      .steps_i    (n_eff),
      .nb_value_i (val[g+1]),
      .nb_sat_i   (sat[g+1]),
      .value_o    (val[g]),
      .sat_o      (sat[g])
    );
  end

  assign option_value_o = val[0];
  assign saturated_o    = sat[0];

endmodule

FILE: design/btop_cell.sv
// One node cell of the tree row: leaf price, payoff and backward induction
module btop_cell import btop_pkg::*; #(
  parameter int unsigned MaxSteps = DefMaxSteps,
  parameter int unsigned Index    = 0,
  localparam int unsigned CntW    = $clog2(MaxSteps + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic [CntW-1:0] step_i,
  input  logic [CntW-1:0] steps_i,
  input  logic [31:0]     nb_value_i,
  input  logic            nb_sat_i,
  output logic [31:0]     value_o,
  output logic            sat_o
);

  localparam logic [CntW:0] IdxC = (CntW + 1)'(Index);

  logic [31:0] v_q, v_d;
  logic [63:0] p_q, p_d;
  logic        sat_q, sat_d;
  logic [31:0] op_a, op_b;
  logic [63:0] op_c, prod;
  logic        clamp, use_down, live_leaf, live_lvl;
  logic [31:0] rnd, payoff;

  assign use_down  = (({1'b0, step_i} + IdxC) < {1'b0, steps_i});
  assign live_leaf = (IdxC <= {1'b0, steps_i});
  assign live_lvl  = (IdxC < {1'b0, step_i});

  always_comb begin
    op_a = v_q;
    op_b = ctl_i.coef;
    op_c = HalfQ30;
    case (ctl_i.op)
      OP_LEAF: op_b = use_down ? ctl_i.coef : ctl_i.coef_alt;
      OP_MIX0: op_c = '0;
      OP_MIX1: begin
        op_a = nb_value_i;
        op_c = p_q + HalfQ30;
      end
      default: ;
    endcase
  end

  assign prod  = 64'(op_a) * 64'(op_b) + op_c;
  assign clamp = |prod[63:62];
  assign rnd   = clamp ? '1 : prod[61:30];

  always_comb begin
    if (ctl_i.is_put) begin
      payoff = (ctl_i.strike > v_q) ? ctl_i.strike - v_q : '0;
    end else begin
      payoff = (v_q > ctl_i.strike) ? v_q - ctl_i.strike : '0;
    end
  end

  always_comb begin
    v_d   = v_q;
    p_d   = p_q;
    sat_d = sat_q;
    case (ctl_i.op)
      OP_LOAD: begin
        v_d   = ctl_i.spot;
        sat_d = 1'b0;
      end
      OP_LEAF: begin
        v_d   = rnd;
        sat_d = sat_q | (clamp & live_leaf);
      end
      OP_PAYOFF: v_d = payoff;
      OP_MIX0:   p_d = prod;
      OP_MIX1:   v_d = prod[61:30];
      OP_DISC: begin
        v_d   = rnd;
        sat_d = sat_q | nb_sat_i | (clamp & live_lvl);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    p_q <= p_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else begin
      sat_q <= sat_d;
    end
  end

  assign value_o = v_q;
  assign sat_o   = sat_q;

endmodule

FILE: design/btop_ctrl.sv
// Sequencer that broadcasts cell operations level by level
module btop_ctrl import btop_pkg::*; #(
  parameter int unsigned MaxSteps = DefMaxSteps,
  localparam int unsigned CntW    = $clog2(MaxSteps + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [31:0]     spot_i,
  input  cfg_t            cfg_i,
  input  logic [CntW-1:0] steps_i,
  output cell_ctl_t       ctl_o,
  output logic [CntW-1:0] step_o,
  output logic            busy_o,
  output logic            done_o
);

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAF,
    S_PAYOFF,
    S_MIX0,
    S_MIX1,
    S_DISC,
    S_DONE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            accept;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign accept = start_i & ~busy_o;
  assign step_o = cnt_q;

  always_comb begin
    ctl_o.op       = OP_HOLD;
    ctl_o.coef     = cfg_i.down;
    ctl_o.coef_alt = cfg_i.up;
    ctl_o.strike   = cfg_i.strike;
    ctl_o.is_put   = cfg_i.is_put;
    ctl_o.spot     = spot_i;
    case (state_q)
      S_IDLE:   ctl_o.op = accept ? OP_LOAD : OP_HOLD;
      S_LEAF:   ctl_o.op = OP_LEAF;
      S_PAYOFF: ctl_o.op = OP_PAYOFF;
      S_MIX0: begin
        ctl_o.op   = OP_MIX0;
        ctl_o.coef = {1'b0, cfg_i.prob_c};
      end
      S_MIX1: begin
        ctl_o.op   = OP_MIX1;
        ctl_o.coef = {1'b0, cfg_i.prob};
      end
      S_DISC: begin
        ctl_o.op   = OP_DISC;
        ctl_o.coef = {1'b0, cfg_i.disc};
      end
      default: ctl_o.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q   <= '0;
            state_q <= (steps_i == '0) ? S_PAYOFF : S_LEAF;
          end
        end
        S_LEAF: begin
          if (cnt_q + 1'b1 == steps_i) begin
            state_q <= S_PAYOFF;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_PAYOFF: begin
          if (steps_i == '0) begin
            state_q <= S_DONE;
          end else begin
            cnt_q   <= steps_i;
            state_q <= S_MIX0;
          end
        end
        S_MIX0: state_q <= S_MIX1;
        S_MIX1: state_q <= S_DISC;
        S_DISC: begin
          if (cnt_q == CntW'(1)) begin
            state_q <= S_DONE;
          end else begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_MIX0;
          end
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NXT(accept_goes_busy, clk_i, rst_ni, accept, busy_o)
  `ASSERT_NXT(done_frees, clk_i, rst_ni, done_o, !busy_o)
  `ASSERT_NXT(busy_holds, clk_i, rst_ni, busy_o && !done_o, busy_o)

endmodule

FILE: test/tb_binomial_tree_option_price.sv
// Testbench for the binomial tree option pricer: predicted root values and saturation flags checked against the block
`timescale 1ns / 100ps

module tb_binomial_tree_option_price;
  import btop_pkg::*;

  localparam int unsigned MaxTreeSteps = 256;
  localparam int unsigned WatchLimit   = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] spot_price_i = '0;
  logic        done_o;
  logic [31:0] option_value_o;
  logic        saturated_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  binomial_tree_option_price u_top (
    .clk_i, .rst_ni, .start, .busy, .spot_price_i, .done_o, .option_value_o,
    .saturated_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } price_t;

  logic        cfg_put;
  logic [31:0] cfg_strike, cfg_up, cfg_down;
  logic [30:0] cfg_prob, cfg_disc;
  logic [8:0]  cfg_steps;

  price_t      price_queue[$];
  logic [31:0] level[MaxTreeSteps + 1];
  int          fail_count = 0;
  int          price_count = 0;
  int          setting_count = 0;
  int          idle_pct = 0;
  int          quiet_cycles = 0;

  function automatic logic [31:0] mul_q30(input logic [31:0] v, input logic [31:0] f,
                                          inout logic sat);
    logic [63:0] p;
    p = ({32'd0, v} * {32'd0, f} + HalfQ30) >> 30;
    if (p > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return p[31:0];
  endfunction

  function automatic price_t price_option(input logic [31:0] spot);
    int unsigned n;
    logic [63:0] q, qc, mix;
    logic [31:0] s, m;
    logic        sat;
    price_t      r;
    n = (cfg_steps > MaxTreeSteps) ? MaxTreeSteps : cfg_steps;
    q = (cfg_prob > OneQ30) ? 64'(OneQ30) : 64'(cfg_prob);
    qc = 64'(OneQ30) - q;
    sat = 1'b0;
    for (int j = 0; j <= n; j++) begin
      s = spot;
      for (int k = 0; k < n - j; k++) s = mul_q30(s, cfg_down, sat);
      for (int k = 0; k < j; k++) s = mul_q30(s, cfg_up, sat);
      if (cfg_put) level[j] = (cfg_strike > s) ? cfg_strike - s : 32'd0;
      else level[j] = (s > cfg_strike) ? s - cfg_strike : 32'd0;
    end
    for (int i = n; i > 0; i--) begin
      for (int j = 0; j < i; j++) begin
        mix = q * level[j + 1] + qc * level[j];
        m = 32'((mix + HalfQ30) >> 30);
        level[j] = mul_q30(m, {1'b0, cfg_disc}, sat);
      end
    end
    r.value = level[0];
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    price_t want;
    logic   moved;
    if (rst_ni) begin
      moved = done_o || (start && !busy);
      if (done_o) begin
        if (price_queue.size() == 0) begin
          report_mismatch("unexpected beat", option_value_o, 32'd0);
        end else begin
          want = price_queue.pop_front();
          if (option_value_o !== want.value)
            report_mismatch("option_value", option_value_o, want.value);
          if (saturated_o !== want.sat)
            report_mismatch("saturated", {31'd0, saturated_o}, {31'd0, want.sat});
        end
      end
      if (moved) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("watchdog expired");
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegPut:    cfg_put = data[0];
      RegStrike: cfg_strike = data;
      RegUp:     cfg_up = data;
      RegDown:   cfg_down = data;
      RegProb:   cfg_prob = data[30:0];
      RegDisc:   cfg_disc = data[30:0];
      RegSteps:  cfg_steps = data[8:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (price_queue.size() == 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic configure(input logic put, input logic [31:0] k, input logic [31:0] u,
                           input logic [31:0] d, input logic [31:0] q, input logic [31:0] r,
                           input logic [31:0] n);
    drain();
    write_reg(RegPut, {31'd0, put});
    write_reg(RegStrike, k);
    write_reg(RegUp, u);
    write_reg(RegDown, d);
    write_reg(RegProb, q);
    write_reg(RegDisc, r);
    write_reg(RegSteps, n);
    setting_count++;
  endtask

  task automatic send_spot(input logic [31:0] spot);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start <= 1'b1;
    spot_price_i <= spot;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    price_queue.push_back(price_option(spot));
    price_count++;
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    cfg_put = 1'b0;
    cfg_strike = '0;
    cfg_up = 32'h4000_0000;
    cfg_down = 32'h4000_0000;
    cfg_prob = 31'h2000_0000;
    cfg_disc = 31'h4000_0000;
    cfg_steps = 9'd1;
    send_spot(32'h0001_0000);
    send_spot(32'hFFFF_FFFF);
  endtask

  task automatic test_directed_corners();
    configure(1'b0, 32'h0001_0000, 32'h4400_0000, 32'h3C00_0000, 32'h2000_0000,
              32'h3FF0_0000, 32'd4);
    send_spot(32'h0000_0000);
    send_spot(32'hFFFF_FFFF);
    send_spot(32'h0002_0000);
    configure(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'd3);
    send_spot(32'h0000_0000);
    send_spot(32'h8000_0000);
    configure(1'b0, 32'h0000_0000, 32'h8000_0000, 32'h4000_0000, 32'h0000_0000,
              32'h0000_0000, 32'd0);
    send_spot(32'h1234_5678);
    configure(1'b1, 32'h0010_0000, 32'h4100_0000, 32'h3F00_0000, 32'h4000_0000,
              32'h4000_0000, 32'h1FF);
    send_spot(32'h000F_0000);
    configure(1'b0, 32'h0001_0000, 32'h4080_0000, 32'h3F80_0000, 32'h2100_0000,
              32'h3FFF_0000, 32'd256);
    send_spot(32'h0001_0000);
    send_spot(32'hFFFF_0000);
  endtask

  task automatic test_random_prices(input int total);
    int done_here;
    done_here = 0;
    while (done_here < total) begin
      configure(1'($urandom_range(1)), $urandom,
                32'h4000_0000 + $urandom_range(32'h0800_0000),
                32'h4000_0000 - $urandom_range(32'h0800_0000),
                ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h4000_0000),
                ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h4000_0000),
                ($urandom_range(19) == 0) ? $urandom_range(511) : $urandom_range(1, 12));
      repeat ($urandom_range(10, 30)) begin
        send_spot(($urandom_range(3) == 0) ? $urandom :
                  {16'($urandom_range(4, 0)), 16'($urandom)});
        done_here++;
        if ($urandom_range(49) == 0) wait (price_queue.size() == 0);
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_directed_corners();
    idle_pct = 33;
    test_random_prices(380);
    idle_pct = 66;
    test_random_prices(380);
    idle_pct = 0;
    test_random_prices(380);
    drain();
    repeat (1100) @(negedge clk_i);
    $display("covered %0d prices over %0d register settings", price_count, setting_count);
    if (fail_count == 0 && price_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
